/* design/pkbed_pkg.sv */
`default_nettype none

package pkbed_pkg;

    localparam int MAX_BLOCK_BYTES_DEFAULT = 65536;

    // Bit 7 of a varint byte says that another byte follows.
    localparam int VARINT_CONT_BIT = 7;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_VALUE  = 2'd2,
        KIND_ERROR  = 2'd3
    } item_kind_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_KEY    = 3'b010,
        PH_VALUE  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
    } in_item_t;

    typedef struct packed {
        item_kind_t  item_kind;
        logic [7:0]  byte_out;
        logic [15:0] key_position;
        logic [15:0] shared_length;
        logic [15:0] suffix_length;
        logic [15:0] value_size;
        logic        entry_last;
        logic        area_end;
    } out_item_t;

endpackage

`default_nettype wire

/* design/prefix_key_block_entry_decoder_top.sv */
`default_nettype none

// Parses the entry area of one sorted-table block, one byte per cycle. Each entry header
// (shared, suffix and value lengths as varint32) yields one header request, then each suffix
// byte a key request at its full key position and each value byte a value request; the final
// request of an entry carries entry_last. Corruption yields one error request and then silence
// until the next byte with block_start. A new byte can be taken in every cycle unless a
// waiting result is stalled; a taken byte is held in the input register, goes through one pass
// of parse logic and has its result registered in the result register, and bytes that cause no
// result simply pass through. The user must write entries_length only while the block is
// idle; the block itself does not enforce this.
module prefix_key_block_entry_decoder_top
    import pkbed_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_item,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    localparam logic [16:0] AREA_CAP =
        (MAX_BLOCK_BYTES > 65536) ? 17'd65536 : 17'(MAX_BLOCK_BYTES);

    logic [15:0] entries_length_reg;

    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        s1_advance;

    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic [15:0] byte_offset_reg,     byte_offset_next;
    phase_t      phase_reg,           phase_next;
    logic [1:0]  header_field_reg,    header_field_next;
    logic [31:0] varint_accum_reg,    varint_accum_next;
    logic [2:0]  varint_count_reg,    varint_count_next;
    logic [31:0] shared_reg,          shared_next;
    logic [31:0] suffix_reg,          suffix_next;
    logic [31:0] value_len_reg,       value_len_next;
    logic [15:0] bytes_left_reg,      bytes_left_next;
    logic [15:0] prev_key_length_reg, prev_key_length_next;
    logic        error_flag_reg,      error_flag_next;

    logic        produce;
    out_item_t   result;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    always_comb
    begin
        logic [15:0] cur_offset;
        phase_t      cur_phase;
        logic [1:0]  cur_field;
        logic [31:0] cur_accum;
        logic [2:0]  cur_count;
        logic [31:0] cur_shared;
        logic [31:0] cur_suffix;
        logic [31:0] cur_value;
        logic [15:0] cur_left;
        logic [15:0] cur_prev;
        logic        cur_error;
        logic [7:0]  b;
        logic [15:0] lim;
        logic [15:0] rem;
        logic [31:0] contrib;
        logic [31:0] vint;
        logic [32:0] body_len;
        logic [15:0] left_dec;
        logic        last;

        // A block start clears the parse state before its own byte is parsed.
        if (s1_item_reg.block_start)
        begin
            cur_offset = '0;
            cur_phase  = PH_HEADER;
            cur_field  = '0;
            cur_accum  = '0;
            cur_count  = '0;
            cur_shared = '0;
            cur_suffix = '0;
            cur_value  = '0;
            cur_left   = '0;
            cur_prev   = '0;
            cur_error  = 1'b0;
        end
        else
        begin
            cur_offset = byte_offset_reg;
            cur_phase  = phase_reg;
            cur_field  = header_field_reg;
            cur_accum  = varint_accum_reg;
            cur_count  = varint_count_reg;
            cur_shared = shared_reg;
            cur_suffix = suffix_reg;
            cur_value  = value_len_reg;
            cur_left   = bytes_left_reg;
            cur_prev   = prev_key_length_reg;
            cur_error  = error_flag_reg;
        end

        b   = s1_item_reg.data_byte;
        lim = ({1'b0, entries_length_reg} > AREA_CAP) ? AREA_CAP[15:0] : entries_length_reg;
        rem = lim - cur_offset - 16'd1;

        // The fifth varint byte lands at bit 28; its upper bits fall off the word.
        if (cur_count[2])
        begin
            contrib = {b[3:0], 28'd0};
        end
        else
        begin
            case (cur_count[1:0])
                2'd0:    contrib = {25'd0, b[6:0]};
                2'd1:    contrib = {18'd0, b[6:0], 7'd0};
                2'd2:    contrib = {11'd0, b[6:0], 14'd0};
                2'd3:    contrib = {4'd0, b[6:0], 21'd0};
                default: contrib = '0;
            endcase
        end
        vint     = cur_accum | contrib;
        body_len = {1'b0, cur_suffix} + {1'b0, vint};
        left_dec = (cur_left != 16'd0) ? cur_left - 16'd1 : cur_left;
        last     = 1'b0;

        byte_offset_next     = (cur_offset != 16'hFFFF) ? cur_offset + 16'd1 : cur_offset;
        phase_next           = cur_phase;
        header_field_next    = cur_field;
        varint_accum_next    = cur_accum;
        varint_count_next    = cur_count;
        shared_next          = cur_shared;
        suffix_next          = cur_suffix;
        value_len_next       = cur_value;
        bytes_left_next      = cur_left;
        prev_key_length_next = cur_prev;
        error_flag_next      = cur_error;

        produce               = 1'b0;
        result.item_kind      = KIND_ERROR;
        result.byte_out       = '0;
        result.key_position   = '0;
        result.shared_length  = '0;
        result.suffix_length  = '0;
        result.value_size     = '0;
        result.entry_last     = 1'b0;
        result.area_end       = 1'b0;

        if (!cur_error && (cur_offset < lim))
        begin
            case (cur_phase)
                PH_KEY, PH_VALUE:
                begin
                    produce                = 1'b1;
                    bytes_left_next        = left_dec;
                    result.byte_out        = b;
                    result.shared_length   = cur_shared[15:0];
                    result.suffix_length   = cur_suffix[15:0];
                    result.value_size      = cur_value[15:0];
                    if (cur_phase == PH_KEY)
                    begin
                        result.item_kind    = KIND_KEY;
                        result.key_position = cur_shared[15:0] + (cur_suffix[15:0] - cur_left);
                    end
                    else
                    begin
                        result.item_kind    = KIND_VALUE;
                    end
                    if (left_dec == 16'd0)
                    begin
                        if ((cur_phase == PH_KEY) && (cur_value != 32'd0))
                        begin
                            phase_next      = PH_VALUE;
                            bytes_left_next = cur_value[15:0];
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                            last       = 1'b1;
                        end
                    end
                    result.entry_last = last;
                    result.area_end   = last && (rem == 16'd0);
                end
                default:
                begin
                    if (cur_count[2] && b[VARINT_CONT_BIT])
                    begin
                        produce         = 1'b1;
                        error_flag_next = 1'b1;
                    end
                    else if (b[VARINT_CONT_BIT])
                    begin
                        varint_accum_next = vint;
                        varint_count_next = cur_count + 3'd1;
                        if (rem == 16'd0)
                        begin
                            produce         = 1'b1;
                            error_flag_next = 1'b1;
                        end
                    end
                    else
                    begin
                        varint_accum_next = '0;
                        varint_count_next = '0;
                        case (cur_field)
                            2'd0:    shared_next    = vint;
                            2'd1:    suffix_next    = vint;
                            default: value_len_next = vint;
                        endcase
                        if (cur_field != 2'd2)
                        begin
                            header_field_next = cur_field + 2'd1;
                            if (rem == 16'd0)
                            begin
                                produce         = 1'b1;
                                error_flag_next = 1'b1;
                            end
                        end
                        else
                        begin
                            header_field_next = '0;
                            produce           = 1'b1;
                            if ((body_len > {17'd0, rem}) || (cur_shared > {16'd0, cur_prev}))
                            begin
                                error_flag_next = 1'b1;
                            end
                            else
                            begin
                                // Suffix and value fit the area; shared fits the last key.
                                prev_key_length_next = cur_shared[15:0] + cur_suffix[15:0];
                                if (cur_suffix != 32'd0)
                                begin
                                    phase_next      = PH_KEY;
                                    bytes_left_next = cur_suffix[15:0];
                                end
                                else if (vint != 32'd0)
                                begin
                                    phase_next      = PH_VALUE;
                                    bytes_left_next = vint[15:0];
                                end
                                else
                                begin
                                    phase_next      = PH_HEADER;
                                    bytes_left_next = '0;
                                    last            = 1'b1;
                                end
                                result.item_kind     = KIND_HEADER;
                                result.shared_length = cur_shared[15:0];
                                result.suffix_length = cur_suffix[15:0];
                                result.value_size    = vint[15:0];
                                result.entry_last    = last;
                                result.area_end      = last && (rem == 16'd0);
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_length_reg  <= '0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            byte_offset_reg     <= '0;
            phase_reg           <= PH_HEADER;
            header_field_reg    <= '0;
            varint_accum_reg    <= '0;
            varint_count_reg    <= '0;
            shared_reg          <= '0;
            suffix_reg          <= '0;
            value_len_reg       <= '0;
            bytes_left_reg      <= '0;
            prev_key_length_reg <= '0;
            error_flag_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                entries_length_reg <= cfg_wr_data;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg       <= produce;
                byte_offset_reg     <= byte_offset_next;
                phase_reg           <= phase_next;
                header_field_reg    <= header_field_next;
                varint_accum_reg    <= varint_accum_next;
                varint_count_reg    <= varint_count_next;
                shared_reg          <= shared_next;
                suffix_reg          <= suffix_next;
                value_len_reg       <= value_len_next;
                bytes_left_reg      <= bytes_left_next;
                prev_key_length_reg <= prev_key_length_next;
                error_flag_reg      <= error_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_advance && produce)
        begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire
